// ===== sv/stroke_point_simplifier_top_defines.svh =====
// Assertion macros for the stroke simplifier top level
`ifndef STROKE_POINT_SIMPLIFIER_TOP_DEFINES_SVH
`define STROKE_POINT_SIMPLIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SPS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stroke simplifier check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SPS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stroke simplifier check failed");

`endif

// ===== sv/sps_pkg.sv =====
package sps_pkg;

	// Coordinate width and derived arithmetic widths
	localparam int COORD_BITS = 12;
	localparam int MS_W       = 10;
	localparam int ST_W       = 7;
	localparam int SQ_W       = 2 * COORD_BITS + 1;   // sum of two squares, dot magnitude
	localparam int ACC_W      = 4 * COORD_BITS + 16;  // scaled squared products
	localparam int TT_W       = 2 * ST_W;
	localparam int DIGIT_W    = 4;
	localparam int KSCALE     = 10000;

	// Stream and configuration widths
	localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = ((6 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = MS_W;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT    = 1'b1;
	localparam logic [MS_W-1:0]      MS_RESET        = 10'd30;
	localparam logic [ST_W-1:0]      ST_RESET        = 7'd96;

	// Item kinds and kept-point limit
	localparam logic OP_POINT  = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam logic [1:0] ACCEPT_COUNT = 2'd3;

	typedef enum logic [2:0] {
		ACT_DROP    = 3'd0,
		ACT_APPEND  = 3'd1,
		ACT_REPLACE = 3'd2,
		ACT_ACCEPT  = 3'd3,
		ACT_REJECT  = 3'd4
	} sps_action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BOX,
		ST_D2X,
		ST_D2Y,
		ST_MS,
		ST_DOTX,
		ST_DOTY,
		ST_NAX,
		ST_NAY,
		ST_DD,
		ST_DDK,
		ST_TT,
		ST_NN,
		ST_NT,
		ST_RESULT
	} sps_state_t;

	typedef struct packed {
		logic [MS_W-1:0] min_spacing;
		logic [ST_W-1:0] straight_hundredths;
	} sps_cfg_t;

	typedef struct packed {
		logic                  op;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} sps_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] box_left;
		logic [COORD_BITS-1:0] box_top;
		logic [COORD_BITS-1:0] box_right;
		logic [COORD_BITS-1:0] box_bottom;
	} sps_box_t;

	localparam sps_box_t BOX_CLEAR = '{
		box_left:   {COORD_BITS{1'b1}},
		box_top:    {COORD_BITS{1'b1}},
		box_right:  {COORD_BITS{1'b0}},
		box_bottom: {COORD_BITS{1'b0}}
	};

	typedef struct packed {
		sps_action_t           action;
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
		sps_box_t              box;
	} sps_res_t;

	// Multiply-accumulate command and status
	typedef struct packed {
		logic             start;
		logic             accum;
		logic             neg;
		logic [ACC_W-1:0] a;
		logic [SQ_W-1:0]  b;
	} sps_mac_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] acc;
	} sps_mac_stat_t;

endpackage

// ===== sv/sps_mac.sv =====
// Digit-serial multiply-accumulate: one multiplier digit per cycle, LSB first
module sps_mac (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sps_pkg::sps_mac_cmd_t  cmd,
	output sps_pkg::sps_mac_stat_t stat
);

	logic                      busy_q;
	logic                      neg_q;
	logic [sps_pkg::ACC_W-1:0] a_q;
	logic [sps_pkg::SQ_W-1:0]  b_q;
	logic [sps_pkg::ACC_W-1:0] acc_q;
	logic [sps_pkg::ACC_W-1:0] pp;
	logic                      last_digit;

	// Partial product of the shifted multiplicand and the current digit
	assign pp         = a_q * {{(sps_pkg::ACC_W - sps_pkg::DIGIT_W){1'b0}},
		b_q[sps_pkg::DIGIT_W-1:0]};
	assign last_digit = (b_q == '0);

	// Run until the multiplier has shifted out all of its set digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && last_digit) begin
			busy_q <= 1'b0;
		end
	end

	// Shift operands one digit and accumulate
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= cmd.a;
			b_q   <= cmd.b;
			neg_q <= cmd.neg;
			if (!cmd.accum) begin
				acc_q <= '0;
			end
		end else if (busy_q && !last_digit) begin
			acc_q <= neg_q ? (acc_q - pp) : (acc_q + pp);
			a_q   <= a_q << sps_pkg::DIGIT_W;
			b_q   <= b_q >> sps_pkg::DIGIT_W;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && last_digit;
	assign stat.acc  = acc_q;

endmodule

// ===== sv/sps_seq.sv =====
// Point sequencer: box tracking, spacing and collinearity tests, kept points
module sps_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sps_pkg::sps_item_t item,
	input  sps_pkg::sps_cfg_t  cfg,
	input  logic               out_free,
	output logic               idle,
	output logic               res_valid,
	output sps_pkg::sps_res_t  res
);

	localparam int CW = sps_pkg::COORD_BITS;

	sps_pkg::sps_state_t    state_q, state_d;
	sps_pkg::sps_item_t     item_q;
	sps_pkg::sps_box_t      box_q, nbox;
	sps_pkg::sps_res_t      res_q;
	sps_pkg::sps_mac_cmd_t  cmd;
	sps_pkg::sps_mac_stat_t mac;
	sps_pkg::sps_action_t   dec_act;

	logic [1:0]                kept_q;
	logic [CW-1:0]             prev_x_q, prev_y_q, last_x_q, last_y_q;
	logic                      launch_q;
	logic [sps_pkg::SQ_W-1:0]  d2_q, dmag_q, na_q;
	logic                      dneg_q;
	logic [sps_pkg::ACC_W-1:0] lhs_q;
	logic [sps_pkg::TT_W-1:0]  tt_q;
	logic [sps_pkg::ACC_W-1:0] acc_neg;
	logic                      dec_valid;
	logic                      mac_state;

	logic [CW:0]   dx_full, dy_full, ax_full, ay_full;
	logic [CW-1:0] dxm, dym, axm, aym;
	logic          sdx, sdy, sax, say;

	sps_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (mac)
	);

	// Signed differences against the last kept point, as sign and magnitude
	assign dx_full = {1'b0, item_q.pos_x} - {1'b0, last_x_q};
	assign dy_full = {1'b0, item_q.pos_y} - {1'b0, last_y_q};
	assign ax_full = {1'b0, prev_x_q} - {1'b0, last_x_q};
	assign ay_full = {1'b0, prev_y_q} - {1'b0, last_y_q};
	assign sdx     = dx_full[CW];
	assign sdy     = dy_full[CW];
	assign sax     = ax_full[CW];
	assign say     = ay_full[CW];
	assign dxm     = sdx ? CW'(-dx_full) : dx_full[CW-1:0];
	assign dym     = sdy ? CW'(-dy_full) : dy_full[CW-1:0];
	assign axm     = sax ? CW'(-ax_full) : ax_full[CW-1:0];
	assign aym     = say ? CW'(-ay_full) : ay_full[CW-1:0];
	assign acc_neg = -mac.acc;

	// Widen the box by the current point
	always_comb begin
		nbox = box_q;
		if (item_q.pos_x < box_q.box_left) begin
			nbox.box_left = item_q.pos_x;
		end
		if (item_q.pos_y < box_q.box_top) begin
			nbox.box_top = item_q.pos_y;
		end
		if (item_q.pos_x > box_q.box_right) begin
			nbox.box_right = item_q.pos_x;
		end
		if (item_q.pos_y > box_q.box_bottom) begin
			nbox.box_bottom = item_q.pos_y;
		end
	end

	// Operand selection, MAC launch and point decisions
	always_comb begin
		cmd       = '0;
		dec_valid = 1'b0;
		dec_act   = sps_pkg::ACT_APPEND;
		mac_state = state_q inside {sps_pkg::ST_D2X, sps_pkg::ST_D2Y, sps_pkg::ST_MS,
			sps_pkg::ST_DOTX, sps_pkg::ST_DOTY, sps_pkg::ST_NAX, sps_pkg::ST_NAY,
			sps_pkg::ST_DD, sps_pkg::ST_DDK, sps_pkg::ST_TT, sps_pkg::ST_NN, sps_pkg::ST_NT};
		cmd.start = mac_state && !launch_q;
		case (state_q)
			sps_pkg::ST_BOX: begin
				if (item_q.op == sps_pkg::OP_FINISH) begin
					dec_valid = 1'b1;
					dec_act   = (kept_q == sps_pkg::ACCEPT_COUNT) ?
						sps_pkg::ACT_ACCEPT : sps_pkg::ACT_REJECT;
				end else if (kept_q == 2'd0) begin
					dec_valid = 1'b1;
				end
			end
			sps_pkg::ST_D2X: begin
				cmd.a = sps_pkg::ACC_W'(dxm);
				cmd.b = sps_pkg::SQ_W'(dxm);
			end
			sps_pkg::ST_D2Y: begin
				cmd.a     = sps_pkg::ACC_W'(dym);
				cmd.b     = sps_pkg::SQ_W'(dym);
				cmd.accum = 1'b1;
			end
			sps_pkg::ST_MS: begin
				cmd.a = sps_pkg::ACC_W'(cfg.min_spacing);
				cmd.b = sps_pkg::SQ_W'(cfg.min_spacing);
				if (mac.done) begin
					if (sps_pkg::ACC_W'(d2_q) < mac.acc) begin
						dec_valid = 1'b1;
						dec_act   = sps_pkg::ACT_DROP;
					end else if (kept_q < 2'd2) begin
						dec_valid = 1'b1;
					end
				end
			end
			sps_pkg::ST_DOTX: begin
				cmd.a   = sps_pkg::ACC_W'(axm);
				cmd.b   = sps_pkg::SQ_W'(dxm);
				cmd.neg = sax ^ sdx;
			end
			sps_pkg::ST_DOTY: begin
				cmd.a     = sps_pkg::ACC_W'(aym);
				cmd.b     = sps_pkg::SQ_W'(dym);
				cmd.neg   = say ^ sdy;
				cmd.accum = 1'b1;
			end
			sps_pkg::ST_NAX: begin
				cmd.a = sps_pkg::ACC_W'(axm);
				cmd.b = sps_pkg::SQ_W'(axm);
			end
			sps_pkg::ST_NAY: begin
				cmd.a     = sps_pkg::ACC_W'(aym);
				cmd.b     = sps_pkg::SQ_W'(aym);
				cmd.accum = 1'b1;
				// Zero vector or non-obtuse turn never merges
				if (mac.done && ((mac.acc[sps_pkg::SQ_W-1:0] == '0) || (d2_q == '0) ||
						!dneg_q)) begin
					dec_valid = 1'b1;
				end
			end
			sps_pkg::ST_DD: begin
				cmd.a = sps_pkg::ACC_W'(dmag_q);
				cmd.b = dmag_q;
			end
			sps_pkg::ST_DDK: begin
				cmd.a = mac.acc;
				cmd.b = sps_pkg::SQ_W'(sps_pkg::KSCALE);
			end
			sps_pkg::ST_TT: begin
				cmd.a = sps_pkg::ACC_W'(cfg.straight_hundredths);
				cmd.b = sps_pkg::SQ_W'(cfg.straight_hundredths);
			end
			sps_pkg::ST_NN: begin
				cmd.a = sps_pkg::ACC_W'(na_q);
				cmd.b = d2_q;
			end
			sps_pkg::ST_NT: begin
				cmd.a = mac.acc;
				cmd.b = sps_pkg::SQ_W'(tt_q);
				if (mac.done) begin
					dec_valid = 1'b1;
					dec_act   = (lhs_q > mac.acc) ? sps_pkg::ACT_REPLACE : sps_pkg::ACT_APPEND;
				end
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sps_pkg::ST_IDLE: begin
				if (start) begin
					state_d = sps_pkg::ST_BOX;
				end
			end
			sps_pkg::ST_BOX: begin
				state_d = dec_valid ? sps_pkg::ST_RESULT : sps_pkg::ST_D2X;
			end
			sps_pkg::ST_D2X: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_D2Y;
				end
			end
			sps_pkg::ST_D2Y: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_MS;
				end
			end
			sps_pkg::ST_MS: begin
				if (mac.done) begin
					state_d = dec_valid ? sps_pkg::ST_RESULT : sps_pkg::ST_DOTX;
				end
			end
			sps_pkg::ST_DOTX: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_DOTY;
				end
			end
			sps_pkg::ST_DOTY: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_NAX;
				end
			end
			sps_pkg::ST_NAX: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_NAY;
				end
			end
			sps_pkg::ST_NAY: begin
				if (mac.done) begin
					state_d = dec_valid ? sps_pkg::ST_RESULT : sps_pkg::ST_DD;
				end
			end
			sps_pkg::ST_DD: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_DDK;
				end
			end
			sps_pkg::ST_DDK: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_TT;
				end
			end
			sps_pkg::ST_TT: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_NN;
				end
			end
			sps_pkg::ST_NN: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_NT;
				end
			end
			sps_pkg::ST_NT: begin
				if (mac.done) begin
					state_d = sps_pkg::ST_RESULT;
				end
			end
			sps_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = sps_pkg::ST_IDLE;
				end
			end
			default: state_d = sps_pkg::ST_IDLE;
		endcase
	end

	// Control and stroke state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sps_pkg::ST_IDLE;
			launch_q <= 1'b0;
			box_q    <= sps_pkg::BOX_CLEAR;
			kept_q   <= 2'd0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else begin
			state_q <= state_d;
			if (mac.done) begin
				launch_q <= 1'b0;
			end else if (cmd.start) begin
				launch_q <= 1'b1;
			end
			if (state_q == sps_pkg::ST_BOX && item_q.op == sps_pkg::OP_POINT) begin
				box_q <= nbox;
			end
			if (dec_valid) begin
				case (dec_act)
					sps_pkg::ACT_APPEND: begin
						prev_x_q <= last_x_q;
						prev_y_q <= last_y_q;
						last_x_q <= item_q.pos_x;
						last_y_q <= item_q.pos_y;
						if (kept_q != sps_pkg::ACCEPT_COUNT) begin
							kept_q <= kept_q + 2'd1;
						end
					end
					sps_pkg::ACT_REPLACE: begin
						last_x_q <= item_q.pos_x;
						last_y_q <= item_q.pos_y;
					end
					sps_pkg::ACT_ACCEPT, sps_pkg::ACT_REJECT: begin
						box_q    <= sps_pkg::BOX_CLEAR;
						kept_q   <= 2'd0;
						prev_x_q <= '0;
						prev_y_q <= '0;
						last_x_q <= '0;
						last_y_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Hold the item, intermediate results and the finished result
	always_ff @(posedge clk) begin
		if (state_q == sps_pkg::ST_IDLE && start) begin
			item_q <= item;
		end
		if (mac.done) begin
			case (state_q)
				sps_pkg::ST_D2Y: d2_q <= mac.acc[sps_pkg::SQ_W-1:0];
				sps_pkg::ST_DOTY: begin
					dneg_q <= mac.acc[sps_pkg::ACC_W-1];
					dmag_q <= acc_neg[sps_pkg::SQ_W-1:0];
				end
				sps_pkg::ST_NAY: na_q  <= mac.acc[sps_pkg::SQ_W-1:0];
				sps_pkg::ST_DDK: lhs_q <= mac.acc;
				sps_pkg::ST_TT:  tt_q  <= mac.acc[sps_pkg::TT_W-1:0];
				default: ;
			endcase
		end
		if (dec_valid) begin
			res_q.action <= dec_act;
			if (dec_act == sps_pkg::ACT_APPEND || dec_act == sps_pkg::ACT_REPLACE) begin
				res_q.out_x <= item_q.pos_x;
				res_q.out_y <= item_q.pos_y;
			end else begin
				res_q.out_x <= '0;
				res_q.out_y <= '0;
			end
			if (state_q == sps_pkg::ST_BOX && item_q.op == sps_pkg::OP_POINT) begin
				res_q.box <= nbox;
			end else begin
				res_q.box <= box_q;
			end
		end
	end

	assign idle      = (state_q == sps_pkg::ST_IDLE);
	assign res_valid = (state_q == sps_pkg::ST_RESULT);
	assign res       = res_q;

endmodule

// ===== sv/stroke_point_simplifier_top.sv =====
// Channel    | Handshake                     | Payload
// -----------+-------------------------------+---------------------------------------
// input      | s_axis_tvalid / s_axis_tready | tdata: pos_x, pos_y; tuser: op
// result     | m_axis_tvalid / m_axis_tready | tdata: out_x .. box_bottom; tuser: action
// register   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item at a time. A finish is settled in the box state; a point settled by the spacing test
// first runs the squared-distance products, and one that runs the full collinearity test also
// the dot, norm and threshold products, all on the 4-bit digit-serial multiply-accumulate unit
// shared by every product. arst_n clears the registers to spacing 30 and threshold 96 and
// empties the stroke. A result waits in the output register while the next item is taken in.
`include "stroke_point_simplifier_top_defines.svh"

module stroke_point_simplifier_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [sps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // pos_x, pos_y
	input  logic [sps_pkg::IN_TUSER_W-1:0]    s_axis_tuser,   // op
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_x, out_y, box_left, box_top, box_right, box_bottom
	output logic [sps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [sps_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,   // action
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = sps_pkg::COORD_BITS;

	sps_pkg::sps_cfg_t  cfg_q;
	sps_pkg::sps_item_t item;
	sps_pkg::sps_res_t  res, out_q;
	logic               seq_idle, res_valid, out_valid_q, out_free, in_xfer;

	// Take register writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_spacing         <= sps_pkg::MS_RESET;
			cfg_q.straight_hundredths <= sps_pkg::ST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sps_pkg::REG_MIN_SPACING: cfg_q.min_spacing <= cfg_data[sps_pkg::MS_W-1:0];
				sps_pkg::REG_STRAIGHT:
					cfg_q.straight_hundredths <= cfg_data[sps_pkg::ST_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the input transfer
	assign s_axis_tready = seq_idle;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign item.op       = s_axis_tuser[0];
	assign item.pos_x    = s_axis_tdata[CW-1:0];
	assign item.pos_y    = s_axis_tdata[2*CW-1:CW];

	sps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer),
		.item      (item),
		.cfg       (cfg_q),
		.out_free  (out_free),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: load when empty or draining
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.action;
	assign m_axis_tdata  = sps_pkg::OUT_TDATA_W'({out_q.box.box_bottom, out_q.box.box_right,
		out_q.box.box_top, out_q.box.box_left, out_q.out_y, out_q.out_x});

	// One item in flight: the sequencer is busy right after an input transfer
	`SPS_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_axis_tready)
	// A result held back by a full output register stays offered
	`SPS_ASSERT_NEXT(a_res_held, res_valid && out_valid_q && !m_axis_tready, res_valid)
	// Dropped points and finish results carry zero coordinates
	`SPS_ASSERT_NOW(a_zero_coords, out_valid_q && (out_q.action == sps_pkg::ACT_DROP ||
		out_q.action == sps_pkg::ACT_ACCEPT || out_q.action == sps_pkg::ACT_REJECT),
		out_q.out_x == '0 && out_q.out_y == '0)
	// A kept point lies inside the reported box
	`SPS_ASSERT_NOW(a_point_in_box, out_valid_q && (out_q.action == sps_pkg::ACT_APPEND ||
		out_q.action == sps_pkg::ACT_REPLACE), out_q.box.box_left <= out_q.out_x &&
		out_q.out_x <= out_q.box.box_right && out_q.box.box_top <= out_q.out_y &&
		out_q.out_y <= out_q.box.box_bottom)

endmodule

// ===== dv/stroke_point_simplifier_top_test.sv =====
module stroke_point_simplifier_top_test;
	import sps_pkg::*;

	localparam int  CB           = COORD_BITS;
	localparam int  CFG_SETTLE   = 8;
	localparam int  TAIL_CYCLES  = 100;
	localparam int  IDLE_PERCENT = 34;
	localparam longint RUN_LIMIT = 4_000_000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // pos_x, pos_y
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;    // op
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// out_x, out_y, box_left, box_top, box_right, box_bottom
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;         // action
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Shadow registers and stroke state of the thinning predictor
	logic [MS_W-1:0] spacing_reg;
	logic [ST_W-1:0] straight_reg;
	sps_box_t        stroke_box;
	logic [1:0]      kept_n;
	logic [CB-1:0]   prev_x, prev_y, last_x, last_y;

	sps_res_t stroke_results_q[$];
	int       fail_count = 0;
	bit       tx_steady = 1'b0;
	bit       rx_steady = 1'b0;
	int       rx_hold_len = 0;
	int       rx_hold_left = 0;

	stroke_point_simplifier_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#(RUN_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic void clear_stroke_state();
		stroke_box = BOX_CLEAR;
		kept_n     = '0;
		prev_x     = '0;
		prev_y     = '0;
		last_x     = '0;
		last_y     = '0;
	endfunction

	// Exact squared cosine test: new point continues the line through the last two kept points
	function automatic bit continues_line(input logic [CB-1:0] px, input logic [CB-1:0] py);
		longint      ax, ay, bx, by, dot, na, nb;
		logic [127:0] dm, wa, wb, wt;
		ax = longint'(prev_x) - longint'(last_x);
		ay = longint'(prev_y) - longint'(last_y);
		bx = longint'(px) - longint'(last_x);
		by = longint'(py) - longint'(last_y);
		dot = ax * bx + ay * by;
		na = ax * ax + ay * ay;
		nb = bx * bx + by * by;
		if (na == 0 || nb == 0 || dot >= 0)
			return 1'b0;
		dm = 128'(-dot);
		wa = 128'(na);
		wb = 128'(nb);
		wt = 128'(straight_reg);
		return (dm * dm * 128'd10000) > (wa * wb * wt * wt);
	endfunction

	// Work out the result of one item and advance the stroke state
	function automatic sps_res_t thin_stroke_point(input logic op, input logic [CB-1:0] px,
			input logic [CB-1:0] py);
		sps_res_t r;
		longint   dx, dy;
		r.out_x = '0;
		r.out_y = '0;
		if (op == OP_FINISH) begin
			r.action = (kept_n >= ACCEPT_COUNT) ? ACT_ACCEPT : ACT_REJECT;
			r.box    = stroke_box;
			clear_stroke_state();
			return r;
		end
		if (px < stroke_box.box_left)   stroke_box.box_left   = px;
		if (py < stroke_box.box_top)    stroke_box.box_top    = py;
		if (px > stroke_box.box_right)  stroke_box.box_right  = px;
		if (py > stroke_box.box_bottom) stroke_box.box_bottom = py;
		dx = longint'(px) - longint'(last_x);
		dy = longint'(py) - longint'(last_y);
		if (kept_n == 2'd0) begin
			last_x   = px;
			last_y   = py;
			kept_n   = 2'd1;
			r.action = ACT_APPEND;
		end else if (dx * dx + dy * dy < longint'(spacing_reg) * longint'(spacing_reg)) begin
			r.action = ACT_DROP;
		end else if (kept_n >= 2'd2 && continues_line(px, py)) begin
			last_x   = px;
			last_y   = py;
			r.action = ACT_REPLACE;
		end else begin
			prev_x = last_x;
			prev_y = last_y;
			last_x = px;
			last_y = py;
			if (kept_n < ACCEPT_COUNT)
				kept_n = kept_n + 2'd1;
			r.action = ACT_APPEND;
		end
		if (r.action != ACT_DROP) begin
			r.out_x = px;
			r.out_y = py;
		end
		r.box = stroke_box;
		return r;
	endfunction

	// Offer one item, with a random gap before it, and log its expected result on transfer
	task automatic send_item(input logic op, input logic [CB-1:0] px, input logic [CB-1:0] py);
		sps_res_t exp_res;
		if (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'({py, px});
		s_axis_tuser  <= IN_TUSER_W'(op);
		do @(posedge clk); while (!s_axis_tready);
		exp_res = thin_stroke_point(op, px, py);
		stroke_results_q.insert(stroke_results_q.size(), exp_res);
	endtask

	// Drop the input valid and wait until every expected result has come back
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (stroke_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		wait_results_drained();
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MIN_SPACING)
			spacing_reg = MS_W'(val);
		else
			straight_reg = ST_W'(val);
	endtask

	task automatic set_thresholds(input int unsigned spacing, input int unsigned straight);
		write_register(REG_MIN_SPACING, spacing);
		write_register(REG_STRAIGHT, straight);
	endtask

	function automatic logic [CB-1:0] clip_coord(input int v);
		if (v < 0)
			return '0;
		if (v > (1 << CB) - 1)
			return '1;
		return CB'(v);
	endfunction

	// Receiver: random stalls, steady stretches, and long hold-offs on request
	always @(posedge clk) begin
		if (rx_hold_len != 0) begin
			rx_hold_left = rx_hold_len;
			rx_hold_len  = 0;
		end
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left  = rx_hold_left - 1;
		end else if (rx_steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		sps_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (stroke_results_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual action %0d tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				want = stroke_results_q.pop_front();
				check_field("action", want.action, m_axis_tuser);
				check_field("out_x", want.out_x, m_axis_tdata[CB-1:0]);
				check_field("out_y", want.out_y, m_axis_tdata[2*CB-1:CB]);
				check_field("box_left", want.box.box_left, m_axis_tdata[3*CB-1:2*CB]);
				check_field("box_top", want.box.box_top, m_axis_tdata[4*CB-1:3*CB]);
				check_field("box_right", want.box.box_right, m_axis_tdata[5*CB-1:4*CB]);
				check_field("box_bottom", want.box.box_bottom, m_axis_tdata[6*CB-1:5*CB]);
			end
		end
	end

	// Reset thresholds: empty finish, drop, merge of a straight run, turn, full-range box
	task automatic test_directed_stroke();
		send_item(OP_FINISH, 12'hABC, 12'h543);
		send_item(OP_POINT, 12'd0, 12'd0);
		send_item(OP_POINT, 12'd10, 12'd10);
		send_item(OP_POINT, 12'd100, 12'd0);
		send_item(OP_POINT, 12'd200, 12'd0);
		send_item(OP_POINT, 12'd200, 12'd150);
		send_item(OP_POINT, 12'd4095, 12'd4095);
		send_item(OP_FINISH, 12'd0, 12'd0);
		send_item(OP_FINISH, 12'd4095, 12'd4095);
	endtask

	// Zero spacing with repeated points, threshold at and above one hundred, widest spacing
	task automatic test_register_extremes();
		set_thresholds(0, 100);
		send_item(OP_POINT, 12'd5, 12'd5);
		send_item(OP_POINT, 12'd5, 12'd5);
		send_item(OP_POINT, 12'd5, 12'd5);
		send_item(OP_POINT, 12'd9, 12'd5);
		send_item(OP_POINT, 12'd13, 12'd5);
		send_item(OP_FINISH, 12'd0, 12'd0);
		write_register(REG_STRAIGHT, 127);
		send_item(OP_POINT, 12'd100, 12'd100);
		send_item(OP_POINT, 12'd200, 12'd100);
		send_item(OP_POINT, 12'd300, 12'd100);
		send_item(OP_FINISH, 12'd0, 12'd0);
		set_thresholds(1023, 0);
		send_item(OP_POINT, 12'd0, 12'd0);
		send_item(OP_POINT, 12'd1000, 12'd0);
		send_item(OP_POINT, 12'd4095, 12'd0);
		send_item(OP_POINT, 12'd4095, 12'd4095);
		send_item(OP_POINT, 12'd0, 12'd4095);
		send_item(OP_FINISH, 12'd0, 12'd0);
	endtask

	// Mostly smooth strokes with jitter, turns and short steps; some noise and unfinished strokes
	task automatic random_strokes(input int n_items);
		int  sent, pts, step, jitter, x, y;
		real theta;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_item(1'($urandom), CB'($urandom), CB'($urandom));
				sent++;
			end else begin
				if ($urandom_range(9) == 0) begin
					x = $urandom_range(1) ? (1 << CB) - 1 : 0;
					y = $urandom_range(1) ? (1 << CB) - 1 : 0;
				end else begin
					x = $urandom_range((1 << CB) - 1);
					y = $urandom_range((1 << CB) - 1);
				end
				theta = $urandom_range(628) / 100.0;
				pts = $urandom_range(14, 2);
				for (int i = 0; i < pts; i++) begin
					send_item(OP_POINT, CB'(x), CB'(y));
					sent++;
					jitter = $urandom_range(70);
					if ($urandom_range(99) < 15)
						theta = theta + $urandom_range(628) / 100.0;
					else
						theta = theta + (jitter - 35) / 100.0;
					if ($urandom_range(99) < 20)
						step = $urandom_range(spacing_reg);
					else
						step = spacing_reg + $urandom_range(60, 1);
					x = clip_coord(x + $rtoi(step * $cos(theta)));
					y = clip_coord(y + $rtoi(step * $sin(theta)));
				end
				if ($urandom_range(9) != 0) begin
					send_item(OP_FINISH, CB'($urandom), CB'($urandom));
					sent++;
				end
			end
		end
	endtask

	// Hold the receiver off while items keep coming so the block backs up its input
	task automatic test_output_hold_off();
		set_thresholds(20, 90);
		rx_hold_len = 400;
		tx_steady   = 1'b1;
		random_strokes(12);
		tx_steady   = 1'b0;
		wait_results_drained();
	endtask

	task automatic test_random_strokes();
		set_thresholds(30, 96);
		random_strokes(60);
		set_thresholds(0, 0);
		random_strokes(50);
		set_thresholds(1023, 100);
		random_strokes(50);
		// steady stretch on both sides
		set_thresholds(8, 127);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		random_strokes(60);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		set_thresholds($urandom_range(60), $urandom_range(100));
		random_strokes(70);
		set_thresholds($urandom_range(1023), $urandom_range(127));
		random_strokes(30);
		set_thresholds(5, 99);
		random_strokes(50);
	endtask

	initial begin
		spacing_reg  = MS_RESET;
		straight_reg = ST_RESET;
		clear_stroke_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_stroke();
		test_register_extremes();
		test_output_hold_off();
		test_random_strokes();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
